### sv/sbda_pkg.sv
// Shared types and constants for the signed binary to decimal ASCII converter.
package sbda_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGITS     = 10;
    localparam int BCD_W      = 4 * DIGITS;
    localparam int CONV_STEPS = VALUE_W;
    localparam int STEP_W     = $clog2(CONV_STEPS);
    localparam int DCNT_W     = $clog2(DIGITS + 1);
    localparam int CHAR_W     = 7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit_sign;
        logic emit_digit;
        logic skip;
        logic digit_last;
    } sbda_cmd_t;

    typedef struct packed {
        logic neg;
        logic top_zero;
    } sbda_status_t;

endpackage

### sv/signed_binary_to_decimal_ascii_top.sv
// Top level of the signed binary to decimal ASCII converter.
// An item is taken when start is high and busy is low. The value is converted by a
// bit-serial double-dabble pass over all 32 bits, then its text goes out one character
// per cycle, with gaps where none is due: '-' for negative values, then the digits
// without leading zeros, last on the final one; each skipped leading zero still takes
// its own step. Each character is shown for one cycle with valid high and cannot be
// held off. Busy stays high through the last digit step, and a new item can be taken
// once busy is low. The final character appears in the same cycle that busy falls.
module signed_binary_to_decimal_ascii_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] value,
    output logic               valid,
    output logic [6:0]         char_code,
    output logic               last
);
    import sbda_pkg::*;

    sbda_cmd_t    cmd;
    sbda_status_t status;

    sbda_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sbda_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .status    (status),
        .valid     (valid),
        .char_code (char_code),
        .last      (last)
    );

endmodule

### sv/sbda_datapath.sv
// Datapath: magnitude and BCD shift registers, double-dabble step, output registers.
module sbda_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [31:0]         value,
    input  sbda_pkg::sbda_cmd_t        cmd,
    output sbda_pkg::sbda_status_t     status,
    output logic                       valid,
    output logic [6:0]                 char_code,
    output logic                       last
);
    import sbda_pkg::*;

    logic [VALUE_W-1:0] mag_reg,  mag_next;
    logic [BCD_W-1:0]   bcd_reg,  bcd_next;
    logic               neg_reg,  neg_next;
    logic               valid_reg, valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic [BCD_W-1:0]   bcd_adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int d = 0; d < DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;
        if (cmd.load)
        begin
            neg_next = value[VALUE_W-1];
            mag_next = value[VALUE_W-1] ? (~value + 32'd1) : value;
            bcd_next = '0;
        end
        if (cmd.shift)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
        end
        if (cmd.skip || cmd.emit_digit)
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        if (cmd.emit_sign)
        begin
            valid_next = 1'b1;
            char_next  = ASCII_MINUS;
            last_next  = 1'b0;
        end
        if (cmd.emit_digit)
        begin
            valid_next = 1'b1;
            char_next  = ASCII_ZERO + {3'd0, bcd_reg[BCD_W-1 -: 4]};
            last_next  = cmd.digit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign status.neg      = neg_reg;
    assign status.top_zero = (bcd_reg[BCD_W-1 -: 4] == 4'd0);
    assign valid           = valid_reg;
    assign char_code       = char_reg;
    assign last            = last_reg;

endmodule

### sv/sbda_ctrl.sv
// Controller: sequences load, conversion steps, sign and digit emission.
module sbda_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  sbda_pkg::sbda_status_t     status,
    output sbda_pkg::sbda_cmd_t        cmd,
    output logic                       busy
);
    import sbda_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0]        state_reg,   state_next;
    logic [STEP_W-1:0] step_reg,    step_next;
    logic [DCNT_W-1:0] dcnt_reg,    dcnt_next;
    logic              started_reg, started_next;

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        dcnt_next    = dcnt_reg;
        started_next = started_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.shift = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(CONV_STEPS - 1))
                    state_next = ST_SIGN;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = status.neg;
                dcnt_next     = DCNT_W'(DIGITS);
                started_next  = 1'b0;
                state_next    = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                dcnt_next = dcnt_reg - 1'b1;
                // leading zeros are dropped, but the ones digit always goes out
                if (!started_reg && status.top_zero && dcnt_reg != DCNT_W'(1))
                    cmd.skip = 1'b1;
                else
                begin
                    cmd.emit_digit = 1'b1;
                    cmd.digit_last = (dcnt_reg == DCNT_W'(1));
                    started_next   = 1'b1;
                    if (dcnt_reg == DCNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            dcnt_reg    <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            dcnt_reg    <= dcnt_next;
            started_reg <= started_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule
